/* sv/byte_pattern_search_assert.svh */
// ---------------------------------------------------------------------------
// byte_pattern_search assertion macros
// shared property forms for the byte pattern search checkers
// ---------------------------------------------------------------------------
`ifndef BYTE_PATTERN_SEARCH_ASSERT_SVH
`define BYTE_PATTERN_SEARCH_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("byte_pattern_search assertion failed");

// next-cycle implication, disabled during reset
`define BPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("byte_pattern_search assertion failed");

`endif

/* sv/bpsrch_pkg.sv */
// ---------------------------------------------------------------------------
// bpsrch_pkg
// types, constants and helpers shared by the byte pattern search block
// ---------------------------------------------------------------------------
package bpsrch_pkg;

   localparam int MAX_PATTERN  = 16;
   localparam int MAX_BUFFER   = 65536;
   localparam int WINDOW_DEPTH = MAX_PATTERN - 1;
   localparam int LEN_W        = 5;
   localparam int IDX_W        = 4;
   localparam int COUNT_W      = 17;
   localparam int OFFSET_W     = 16;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH   = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                match_found;
      logic [OFFSET_W-1:0] match_offset;
   } rsp_type;

   // per-cell control from the top level
   typedef struct packed {
      logic shift;
      logic active;
   } cell_ctrl_type;

   function automatic logic [7:0] pattern_byte(input logic [63:0]      low,
                                               input logic [63:0]      high,
                                               input logic [IDX_W-1:0] idx);
      logic [5:0] base;
      base = {idx[2:0], 3'b000};
      if (idx[3]) begin
         return high[base +: 8];
      end else begin
         return low[base +: 8];
      end
   endfunction

endpackage

/* sv/bpsrch_cell.sv */
// ---------------------------------------------------------------------------
// bpsrch_cell
// one window cell: holds a past byte, shifts it on, compares it to the pattern
// ---------------------------------------------------------------------------
module bpsrch_cell (
   input  logic                      clock,
   input  bpsrch_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]                byte_in,
   input  logic [7:0]                pattern_in,
   output logic [7:0]                byte_out,
   output logic                      hit
);
   import bpsrch_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in_mux;

   assign byte_in_mux = ctrl.shift ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in_mux;
   end

   // cells beyond the pattern length always agree
   assign hit      = !ctrl.active || (byte_ff == pattern_in);
   assign byte_out = byte_ff;

endmodule

/* sv/byte_pattern_search.sv */
// ---------------------------------------------------------------------------
// byte_pattern_search
// first-occurrence search of a 1 to 16 byte pattern in a byte stream
// ---------------------------------------------------------------------------
// channel   dir  payload                      handshake
// req       in   data_byte, last_byte         req_valid / req_stall
// rsp       out  match_found, match_offset    rsp_valid / rsp_stall
// csr       in   pattern length and bytes     csr_we, no wait
//
// one byte per cycle while req_stall is low: the 15-cell window compares in parallel with the
// current byte, and the result is registered in the output stage.
// result appears in the cycle after the byte that causes it.
// req_stall rises only while a result sits in the output stage and rsp_stall is high.
// synchronous reset clears the count, found flag, output valid and pattern registers.
module byte_pattern_search (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  bpsrch_pkg::req_type                        req_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output bpsrch_pkg::rsp_type                        rsp_data,
   input  logic                                       csr_we,
   input  logic [bpsrch_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [bpsrch_pkg::CSR_DATA_W-1:0]          csr_wdata
);
   import bpsrch_pkg::*;

   logic [LEN_W-1:0]   len_ff, len_in;
   logic [63:0]        pat_low_ff, pat_low_in;
   logic [63:0]        pat_high_ff, pat_high_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0]   len_eff;
   logic               accept;
   logic               match;
   logic               produce;
   logic               cur_hit;
   logic [COUNT_W-1:0] seen_plus;
   logic               saturated;
   logic [7:0]         window [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] cell_hit;

   assign len_eff   = (len_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_ff;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // window cells, cell k holds the byte k+1 positions back
   for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
      cell_ctrl_type    ctrl;
      logic [IDX_W-1:0] pidx;
      logic [7:0]       prev;

      assign ctrl.shift  = accept && !req_data.last_byte;
      assign ctrl.active = len_eff > LEN_W'(k + 1);
      assign pidx        = IDX_W'(len_eff - LEN_W'(k + 2));
      if (k == 0) begin : g_head
         assign prev = req_data.data_byte;
      end else begin : g_body
         assign prev = window[k-1];
      end

      bpsrch_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .byte_in    (prev),
         .pattern_in (pattern_byte(pat_low_ff, pat_high_ff, pidx)),
         .byte_out   (window[k]),
         .hit        (cell_hit[k])
      );
   end

   assign cur_hit   = pattern_byte(pat_low_ff, pat_high_ff, IDX_W'(len_eff - LEN_W'(1)))
                      == req_data.data_byte;
   assign seen_plus = seen_ff + COUNT_W'(1);
   assign saturated = seen_ff >= COUNT_W'(MAX_BUFFER);
   assign match     = !found_ff && (len_eff != '0) && !saturated &&
                      (seen_plus >= COUNT_W'(len_eff)) && cur_hit && (&cell_hit);
   assign produce   = match || (req_data.last_byte && !found_ff);

   always_comb begin
      len_in      = len_ff;
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: len_in      = csr_wdata[LEN_W-1:0];
            CSR_PATTERN_LOW:    pat_low_in  = csr_wdata;
            CSR_PATTERN_HIGH:   pat_high_in = csr_wdata;
            default:            ;
         endcase
      end
   end

   always_comb begin
      seen_in  = seen_ff;
      found_in = found_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            seen_in  = '0;
            found_in = 1'b0;
         end else begin
            found_in = found_ff || match;
            if (!saturated) begin
               seen_in = seen_plus;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept && produce) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.match_found  = match;
         rsp_data_in.match_offset = match ? OFFSET_W'(seen_plus - COUNT_W'(len_eff))
                                          : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         pat_low_ff   <= pat_low_in;
         pat_high_ff  <= pat_high_in;
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/bpsrch_checker.sv */
// ---------------------------------------------------------------------------
// bpsrch_checker
// port-level checks on the byte pattern search block
// ---------------------------------------------------------------------------
`include "byte_pattern_search_assert.svh"

module bpsrch_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input bpsrch_pkg::rsp_type rsp_data,
   input logic                rsp_valid,
   input logic                rsp_stall
);
   import bpsrch_pkg::*;

   // a held result stays offered
   `BPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a held result keeps its payload
   `BPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // not-found transactions carry a zero offset
   `BPS_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_data.match_found, rsp_data.match_offset == '0)

   // input only backs up behind a stalled result
   `BPS_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

bind byte_pattern_search bpsrch_checker u_bpsrch_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

/* verif/search_result_checker.sv */
// ---------------------------------------------------------------------------
// search_result_checker
// watches the byte and result channels of the pattern search, predicts the
// found / not-found result of every buffer and compares field by field
// ---------------------------------------------------------------------------
module search_result_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  bpsrch_pkg::req_type                req_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  bpsrch_pkg::rsp_type                rsp_data,
   input  logic                               csr_we,
   input  logic [bpsrch_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpsrch_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                 mismatch_count,
   output int                                 open_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import bpsrch_pkg::*;

   // configuration copy
   logic [LEN_W-1:0]      length_code;
   logic [63:0]           pattern_low;
   logic [63:0]           pattern_high;

   // search state
   logic [7:0]            window_bytes [WINDOW_DEPTH];
   logic [COUNT_W-1:0]    seen_count;
   logic                  found_flag;

   rsp_type               expected_matches [$];
   int                    fail_tally;

   function automatic logic [7:0] pattern_at(input int k);
      logic [127:0] bits;
      bits = {pattern_high, pattern_low};
      return bits[8*k +: 8];
   endfunction

   task automatic clear_search();
      int k;
      for (k = 0; k < WINDOW_DEPTH; k++) begin
         window_bytes[k] = 8'h00;
      end
      seen_count = '0;
      found_flag = 1'b0;
   endtask

   task automatic predict_search(input req_type item);
      int      len;
      int      k;
      logic    hit;
      rsp_type res;
      len = (int'(length_code) > MAX_PATTERN) ? MAX_PATTERN : int'(length_code);
      hit = 1'b0;
      // window ending at the current byte, only bytes of this buffer count
      if (!found_flag && len != 0 && int'(seen_count) < MAX_BUFFER &&
          int'(seen_count) + 1 >= len) begin
         hit = (pattern_at(len - 1) == item.data_byte);
         for (k = 0; k + 1 < len; k++) begin
            if (pattern_at(len - 2 - k) != window_bytes[k]) begin
               hit = 1'b0;
            end
         end
      end
      if (hit) begin
         res.match_found  = 1'b1;
         res.match_offset = OFFSET_W'(int'(seen_count) + 1 - len);
         expected_matches.push_back(res);
         found_flag = 1'b1;
      end
      if (item.last_byte) begin
         if (!found_flag) begin
            res.match_found  = 1'b0;
            res.match_offset = '0;
            expected_matches.push_back(res);
         end
         clear_search();
      end else begin
         for (k = WINDOW_DEPTH - 1; k > 0; k--) begin
            window_bytes[k] = window_bytes[k-1];
         end
         window_bytes[0] = item.data_byte;
         if (int'(seen_count) < MAX_BUFFER) begin
            seen_count = seen_count + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         length_code  = '0;
         pattern_low  = '0;
         pattern_high = '0;
         clear_search();
         expected_matches.delete();
      end else begin
         // results are registered behind their byte, so check before predicting
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: result with none expected: found %0b offset %0d", $time,
                        rsp_data.match_found, rsp_data.match_offset);
               fail_tally++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_data.match_found !== want.match_found) begin
                  $display("%0t: match_found expected %0b actual %0b", $time,
                           want.match_found, rsp_data.match_found);
                  fail_tally++;
               end
               if (rsp_data.match_offset !== want.match_offset) begin
                  $display("%0t: match_offset expected %0d actual %0d", $time,
                           want.match_offset, rsp_data.match_offset);
                  fail_tally++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_search(req_data);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_LENGTH: length_code  = csr_wdata[LEN_W-1:0];
               CSR_PATTERN_LOW:    pattern_low  = csr_wdata;
               CSR_PATTERN_HIGH:   pattern_high = csr_wdata;
               default: ;
            endcase
         end
      end
      mismatch_count <= fail_tally;
      open_results   <= expected_matches.size();
   end

   initial begin
      fail_tally     = 0;
      mismatch_count = 0;
      open_results   = 0;
   end

endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// drives byte buffers and pattern settings into byte_pattern_search, with
// bursty sending and patterned result stalls; the checker beside the block
// predicts every result and the verdict is taken from its failure and open-result count
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bpsrch_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_ITEMS    = 64;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int                     mismatch_count;
   int                     open_results;

   // stimulus-side view of the current pattern
   logic [127:0]           pattern_image = '0;
   logic [LEN_W-1:0]       length_code = '0;

   int                     burst_left = 0;
   logic                   steady_sender = 1'b0;
   int                     items_sent = 0;
   int                     stall_mode = 0;
   int                     stall_hold = 0;
   int                     quiet_cycles = 0;

   byte_pattern_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   search_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .open_results   (open_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result stall pattern: free, random, heavy, or solid runs
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_hold = $urandom_range(8, 40);
      end
      stall_hold--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= 1'($urandom_range(0, 1));
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [63:0] random_word();
      return {32'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [7:0] noise_byte(input int eff);
      int k;
      if (eff > 0 && $urandom_range(0, 1) == 1) begin
         k = $urandom_range(0, eff - 1);
         return pattern_image[8*k +: 8];
      end
      return 8'($urandom);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap = steady_sender ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{data_byte: value, last_byte: is_last};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // stop sending until every expected result is out, then let the block settle
   task automatic drain_results();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_pattern(input logic [LEN_W-1:0] len, input logic [63:0] low,
                               input logic [63:0] high);
      csr_we    <= 1'b1;
      csr_index <= CSR_PATTERN_LENGTH;
      csr_wdata <= {32'($urandom), 27'($urandom), len};
      @(posedge clock);
      csr_index <= CSR_PATTERN_LOW;
      csr_wdata <= low;
      @(posedge clock);
      csr_index <= CSR_PATTERN_HIGH;
      csr_wdata <= high;
      @(posedge clock);
      // unmapped index must be ignored
      csr_index <= CSR_UNUSED;
      csr_wdata <= random_word();
      @(posedge clock);
      csr_we <= 1'b0;
      length_code   = len;
      pattern_image = {high, low};
   endtask

   // noise, then the pattern whole, with one bit flipped, or left out, then noise
   task automatic send_buffer();
      logic [7:0] bytes_q [$];
      logic [7:0] b;
      int         eff;
      int         shape;
      int         pre;
      int         post;
      int         flip;
      int         k;
      eff   = (int'(length_code) > MAX_PATTERN) ? MAX_PATTERN : int'(length_code);
      shape = $urandom_range(0, 9);
      pre   = $urandom_range(0, 8);
      post  = $urandom_range(0, 5);
      flip  = (eff > 0) ? $urandom_range(0, eff - 1) : 0;
      repeat (pre) bytes_q.push_back(noise_byte(eff));
      if (shape < 9 && eff > 0) begin
         for (k = 0; k < eff; k++) begin
            b = pattern_image[8*k +: 8];
            if (shape >= 7 && k == flip) begin
               b = b ^ (8'd1 << $urandom_range(0, 7));
            end
            bytes_q.push_back(b);
         end
      end
      repeat (post) bytes_q.push_back(noise_byte(eff));
      if (bytes_q.size() == 0) begin
         bytes_q.push_back(noise_byte(eff));
      end
      for (k = 0; k < bytes_q.size(); k++) begin
         send_byte(bytes_q[k], k == bytes_q.size() - 1);
      end
   endtask

   initial begin
      int         phase;
      int         start;
      int         k;
      logic [4:0] len;
      logic [7:0] b;
      logic [63:0] low;
      logic [63:0] high;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero length, never matches
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      drain_results();

      // match at offset one, trailing bytes ignored after the match
      load_pattern(5'd3, {32'($urandom), 8'($urandom), 24'h434241}, random_word());
      send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h43, 1'b0);
      send_byte(8'h43, 1'b1);
      drain_results();

      // buffer shorter than the pattern, then a match on the last byte
      load_pattern(5'd2, {48'($urandom), 16'h0000}, random_word());
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      drain_results();

      // pattern rewritten in the middle of a buffer keeps window and count
      load_pattern(5'd1, {56'($urandom), 8'h7E}, random_word());
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      drain_results();
      load_pattern(5'd2, {48'($urandom), 16'h3322}, random_word());
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b1);
      drain_results();

      // overlong length acts as sixteen bytes
      load_pattern(5'd31, random_word(), random_word());
      for (k = 0; k < MAX_PATTERN; k++) begin
         send_byte(pattern_image[8*k +: 8], k == MAX_PATTERN - 1);
      end
      drain_results();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       len = 5'd1;
            1:       len = 5'd16;
            2:       len = 5'd0;
            3:       len = 5'd17;
            4:       len = 5'd31;
            default: len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                       : 5'($urandom_range(1, 6));
         endcase
         low  = random_word();
         high = random_word();
         // repeated bytes give overlapping partial matches
         if ($urandom_range(0, 3) == 0) begin
            b    = 8'($urandom);
            low  = {8{b}};
            high = {8{b}};
         end
         load_pattern(len, low, high);
         steady_sender = ($urandom_range(0, 2) == 0);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            send_buffer();
         end
         drain_results();
      end

      if (mismatch_count == 0 && open_results == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/bpsrch_pkg.sv
sv/bpsrch_cell.sv
sv/byte_pattern_search.sv
sv/bpsrch_checker.sv
verif/search_result_checker.sv
verif/tb_top.sv
